>>> sv/fdp_pkg.sv
// Package: widths, coefficient ROM, MAC control struct and state type for the FIR decimator.
package fdp_pkg;

    // Filter geometry
    localparam int TAPS       = 128;
    localparam int COEF_WIDTH = 16;
    localparam int ROM_SIZE   = 128;
    localparam int DEPTH      = TAPS - 1;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int PCM_W    = 8;

    // Derived widths
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int K_W    = $clog2(TAPS);
    localparam int PROD_W = SAMPLE_W + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    // Output scaling: divide by 256, offset by midscale
    localparam int BYP_SHIFT = 8;
    localparam int SHIFT     = COEF_WIDTH - 1 + BYP_SHIFT;
    localparam int Q_W       = ACC_W - SHIFT;
    localparam int PCM_MID   = 128;
    localparam int PCM_MAX   = (1 << PCM_W) - 1;

    // Q1.15 low-pass coefficients, tap t uses entry ROM_SIZE-1-t
    localparam int COEF_ROM [ROM_SIZE] = '{
        -147, -4, 149, 124, -55, -173, -81, 114, 176, 23,
        -165, -156, 46, 200, 113, -118, -213, -49, 184, 199,
        -32, -235, -156, 121, 263, 85, -209, -259, 11, 283,
        219, -124, -334, -140, 243, 349, 24, -357, -318, 126,
        450, 233, -301, -506, -87, 490, 507, -127, -682, -430,
        455, 863, 243, -825, -1019, 128, 1427, 1141, -919, -2617,
        -1217, 3796, 9634, 12221,
        9634, 3796, -1217, -2617, -919, 1141, 1427, 128, -1019, -825,
        243, 863, 455, -430, -682, -127, 507, 490, -87, -506,
        -301, 233, 450, 126, -318, -357, 24, 349, 243, -140,
        -334, -124, 219, 283, 11, -259, -209, 85, 263, 121,
        -156, -235, -32, 199, 184, -49, -213, -118, 113, 200,
        46, -156, -165, 23, 176, 114, -81, -173, -55, 124,
        149, -4, -147,
        -110
    };

    // Coefficient of tap t in Q1.(COEF_WIDTH-1); zero past the ROM
    function automatic logic signed [COEF_WIDTH-1:0] fdp_coef(input int t);
        int q;
        int s;
        int v;
        v = 0;
        if (t < ROM_SIZE) begin
            q = COEF_ROM[ROM_SIZE - 1 - t];
            if (COEF_WIDTH >= 16) begin
                v = q * (1 << (COEF_WIDTH - 16));
            end else begin
                s = 16 - COEF_WIDTH;
                v = ((q + 32768 + (1 << (s - 1))) >>> s) - (32768 >>> s);
            end
        end
        return COEF_WIDTH'(v);
    endfunction

    // Control for one MAC step
    typedef struct packed {
        logic           clear;
        logic           issue;
        logic           cur;
        logic           ok;
        logic [K_W-1:0] k;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FIN,
        ST_PUT
    } t_state;

endpackage

>>> sv/fdp_sample_if.sv
// Interface: input sample channel.
interface fdp_sample_if;
    import fdp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> sv/fdp_result_if.sv
// Interface: 8-bit PCM result channel.
interface fdp_result_if;
    import fdp_pkg::*;

    logic             valid;
    logic             ready;
    logic [PCM_W-1:0] pcm;
    logic             clipped;

    modport source (output valid, output pcm, output clipped, input ready);
    modport sink   (input valid, input pcm, input clipped, output ready);
endinterface

>>> sv/fdp_cfg_if.sv
// Interface: filter_enable register write channel.
interface fdp_cfg_if;
    logic valid;
    logic ready;
    logic filter_enable;

    modport source (output valid, output filter_enable, input ready);
    modport sink   (input valid, input filter_enable, output ready);
endinterface

>>> sv/fir_decimate_to_pcm8.sv
// Top level: 128-tap FIR low-pass (bypassable), decimate by two, convert to 8-bit unsigned PCM.
//
//  channel    dir  handshake      payload
//  i_sample   in   valid/ready    sample (s16)
//  o_result   out  valid/ready    pcm (u8), clipped (1)
//  i_cfg      in   valid/ready    filter_enable (1), always ready
//
// A skipped sample is only written to the delay line. A kept, filtered sample passes through
// the accept cycle, one MAC step per tap (TAPS steps) through the delay-line memory read port,
// the pipeline drain, the FIN scaling state and the output load. A kept, bypassed sample is
// written in its accept cycle and goes on to the output load in the PUT state. The delay line
// needs no clearing pass: a fill count masks slots not yet written since reset. A
// stalled output holds its word; one more kept result can finish and then waits in
// the PUT state.
module fir_decimate_to_pcm8 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fdp_sample_if.sink          i_sample,
    fdp_result_if.source        o_result,
    fdp_cfg_if.sink             i_cfg
);
    import fdp_pkg::*;

    t_state                     r_state;
    t_state                     n_state;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [PTR_W-1:0]           r_wp;
    logic [PTR_W-1:0]           r_rp;
    logic [FILL_W-1:0]          r_fill;
    logic [K_W-1:0]             r_k;
    logic                       r_keep;
    logic                       r_en;
    logic signed [Q_W-1:0]      r_q;
    logic                       r_out_v;
    logic [PCM_W-1:0]           r_pcm;
    logic                       r_clip;

    // Delay-line memory
    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd;

    logic                       w_acc_in;
    logic                       w_we;
    logic signed [SAMPLE_W-1:0] w_wd;
    logic                       w_load;
    t_mac_ctl                   w_ctl;
    logic signed [ACC_W-1:0]    w_acc;
    logic                       w_busy;
    logic signed [SAMPLE_W:0]   w_bsum;
    logic signed [SAMPLE_W:0]   w_bq;
    logic signed [ACC_W-1:0]    w_fsum;
    logic signed [ACC_W-1:0]    w_fq;
    logic signed [Q_W:0]        w_v;
    logic [PCM_W-1:0]           w_pcm;
    logic                       w_clip;
    logic [PTR_W-1:0]           w_rp0;

    fdp_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_x       (r_x),
        .i_rd_data (r_rd),
        .o_acc     (w_acc),
        .o_busy    (w_busy)
    );

    assign i_sample.ready = (r_state == ST_IDLE);
    assign w_acc_in       = i_sample.valid & i_sample.ready;
    assign i_cfg.ready    = 1'b1;

    // Bypass scaling: divide by 256 toward zero
    always_comb begin
        w_bsum = {i_sample.sample[SAMPLE_W-1], i_sample.sample}
               + (i_sample.sample[SAMPLE_W-1] ? (SAMPLE_W+1)'((1 << BYP_SHIFT) - 1)
                                              : (SAMPLE_W+1)'(0));
        w_bq   = w_bsum >>> BYP_SHIFT;
    end

    // Filter scaling: divide accumulator toward zero
    always_comb begin
        w_fsum = w_acc + (w_acc[ACC_W-1] ? ACC_W'((64'(1) << SHIFT) - 64'(1)) : ACC_W'(0));
        w_fq   = w_fsum >>> SHIFT;
    end

    // Offset and saturate
    always_comb begin
        w_v = {r_q[Q_W-1], r_q} + (Q_W+1)'(PCM_MID);
        if (w_v[Q_W]) begin
            w_pcm  = '0;
            w_clip = 1'b1;
        end else if (w_v > (Q_W+1)'(PCM_MAX)) begin
            w_pcm  = PCM_W'(PCM_MAX);
            w_clip = 1'b1;
        end else begin
            w_pcm  = w_v[PCM_W-1:0];
            w_clip = 1'b0;
        end
    end

    // Slot of the previous sample
    assign w_rp0 = (r_wp == '0) ? PTR_W'(DEPTH - 1) : r_wp - 1'b1;

    // Next state, memory write and MAC control
    always_comb begin
        n_state     = r_state;
        w_we        = 1'b0;
        w_wd        = i_sample.sample;
        w_load      = 1'b0;
        w_ctl       = '0;
        w_ctl.k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_in) begin
                    if (!r_keep && r_en) begin
                        w_ctl.clear = 1'b1;
                        n_state     = ST_MAC;
                    end else begin
                        w_we = 1'b1;
                        if (!r_keep) begin
                            n_state = ST_PUT;
                        end
                    end
                end
            end
            ST_MAC: begin
                w_ctl.issue = 1'b1;
                w_ctl.cur   = (r_k == '0);
                w_ctl.ok    = (r_fill == FILL_W'(DEPTH)) || (FILL_W'(r_rp) < r_fill);
                if (r_k == K_W'(DEPTH)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                w_we    = 1'b1;
                w_wd    = r_x;
                n_state = ST_PUT;
            end
            ST_PUT: begin
                if (!r_out_v || o_result.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_keep  <= 1'b0;
            r_en    <= 1'b1;
            r_out_v <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_en <= i_cfg.filter_enable;
            end
            // Pointer, fill count and keep phase advance once per word
            if (w_we) begin
                r_wp   <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
                r_keep <= ~r_keep;
                if (r_fill != FILL_W'(DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            // Tap counter
            if (r_state == ST_MAC) begin
                r_k <= r_k + 1'b1;
            end else begin
                r_k <= '0;
            end
            // Output register
            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (o_result.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_x <= i_sample.sample;
            r_q <= Q_W'(w_bq);
        end else if (r_state == ST_FIN) begin
            r_q <= Q_W'(w_fq);
        end
        // Read pointer walks back one slot per tap after the current one
        if (r_state == ST_IDLE) begin
            r_rp <= w_rp0;
        end else if (r_state == ST_MAC && r_k != '0) begin
            r_rp <= (r_rp == '0) ? PTR_W'(DEPTH - 1) : r_rp - 1'b1;
        end
        if (w_load) begin
            r_pcm  <= w_pcm;
            r_clip <= w_clip;
        end
    end

    // Delay-line memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_wp] <= w_wd;
        end
        r_rd <= mem[r_rp];
    end

    assign o_result.valid   = r_out_v;
    assign o_result.pcm     = r_pcm;
    assign o_result.clipped = r_clip;
endmodule

>>> sv/fdp_mac.sv
// Multiply-accumulate pipeline with coefficient lookup for the FIR.
module fdp_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fdp_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [fdp_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [fdp_pkg::SAMPLE_W-1:0] i_rd_data,
    output logic signed [fdp_pkg::ACC_W-1:0]    o_acc,
    output logic                               o_busy
);
    import fdp_pkg::*;

    t_mac_ctl                   r_s1;
    logic                       r_v2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] w_op;
    logic signed [COEF_WIDTH-1:0] w_coef;
    logic signed [PROD_W-1:0]   w_prod;

    // Stage 1: control aligned with memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_v2 <= 1'b0;
        end else begin
            r_s1 <= i_ctl;
            r_v2 <= r_s1.issue;
        end
    end

    // Operand select: current sample, stored sample, or zero for unwritten slots
    always_comb begin
        if (r_s1.cur) begin
            w_op = i_x;
        end else if (r_s1.ok) begin
            w_op = i_rd_data;
        end else begin
            w_op = '0;
        end
        w_coef = fdp_coef(int'(r_s1.k));
        w_prod = w_op * w_coef;
    end

    // Stage 2: product register
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // Stage 3: accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_s1.issue | r_v2;
endmodule

>>> tb/sv/fdp_pcm_checker.sv
`timescale 1ns / 100ps
// Checker for the FIR decimator: predicts PCM words from accepted samples and compares results.
module fdp_pcm_checker
    import fdp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    fdp_sample_if i_smp,
    fdp_result_if i_res,
    fdp_cfg_if    i_cfg,
    output int    o_fail_cnt,
    output int    o_pending
);

    localparam int NTAPS     = 128;
    localparam int DL_DEPTH  = NTAPS - 1;
    localparam int FIR_SHIFT = 15 + 8;   // Q1.15 product scale plus divide by 256
    localparam int BYP_DIV   = 8;        // divide by 256
    localparam int MIDSCALE  = 128;
    localparam int FULLSCALE = 255;

    // Low-pass coefficients in Q1.15; tap t uses entry NTAPS-1-t
    localparam int LPF_Q15 [NTAPS] = '{
        -147, -4, 149, 124, -55, -173, -81, 114, 176, 23,
        -165, -156, 46, 200, 113, -118, -213, -49, 184, 199,
        -32, -235, -156, 121, 263, 85, -209, -259, 11, 283,
        219, -124, -334, -140, 243, 349, 24, -357, -318, 126,
        450, 233, -301, -506, -87, 490, 507, -127, -682, -430,
        455, 863, 243, -825, -1019, 128, 1427, 1141, -919, -2617,
        -1217, 3796, 9634, 12221,
        9634, 3796, -1217, -2617, -919, 1141, 1427, 128, -1019, -825,
        243, 863, 455, -430, -682, -127, 507, 490, -87, -506,
        -301, 233, 450, 126, -318, -357, 24, 349, 243, -140,
        -334, -124, 219, 283, 11, -259, -209, 85, 263, 121,
        -156, -235, -32, 199, 184, -49, -213, -118, 113, 200,
        46, -156, -165, 23, 176, 114, -81, -173, -55, 124,
        149, -4, -147,
        -110
    };

    typedef struct packed {
        logic [PCM_W-1:0] pcm;
        logic             clipped;
    } pcm_word_t;

    // Shadow of the filter state
    logic signed [SAMPLE_W-1:0] hist [DL_DEPTH];
    int                         hist_wr;
    logic                       keep_odd;
    logic                       filt_on;

    pcm_word_t expected_pcm [$];
    int        fails;

    // Shift one sample into the history; on a kept phase, queue the PCM word it yields
    function automatic void absorb_sample(input logic signed [SAMPLE_W-1:0] x);
        longint    acc;
        longint    mag;
        longint    lvl;
        int        k;
        int        idx;
        pcm_word_t w;
        if (!keep_odd) begin
            if (filt_on) begin
                acc = longint'(LPF_Q15[NTAPS-1]) * longint'(x);
                for (k = 1; k <= DL_DEPTH; k++) begin
                    idx = (hist_wr + DL_DEPTH - k) % DL_DEPTH;
                    acc += longint'(LPF_Q15[NTAPS-1-k]) * longint'(hist[idx]);
                end
                mag = (acc < 0) ? -acc : acc;
                mag = mag >> FIR_SHIFT;
            end else begin
                acc = longint'(x);
                mag = (acc < 0) ? -acc : acc;
                mag = mag >> BYP_DIV;
            end
            // truncate toward zero, then offset to unsigned
            lvl = ((acc < 0) ? -mag : mag) + MIDSCALE;
            if (lvl < 0) begin
                w.pcm     = '0;
                w.clipped = 1'b1;
            end else if (lvl > FULLSCALE) begin
                w.pcm     = PCM_W'(FULLSCALE);
                w.clipped = 1'b1;
            end else begin
                w.pcm     = PCM_W'(lvl);
                w.clipped = 1'b0;
            end
            expected_pcm.push_back(w);
        end
        hist[hist_wr] = x;
        hist_wr       = (hist_wr + 1) % DL_DEPTH;
        keep_odd      = ~keep_odd;
    endfunction

    // Monitor all three channels on the clock
    always @(posedge i_clk) begin
        pcm_word_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < DL_DEPTH; i++) hist[i] = '0;
            hist_wr  = 0;
            keep_odd = 1'b0;
            filt_on  = 1'b1;
            expected_pcm.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_pcm.size() == 0) begin
                    $error("unexpected result word: pcm %0d clipped %0d",
                           i_res.pcm, i_res.clipped);
                    fails++;
                end else begin
                    want = expected_pcm.pop_front();
                    if (i_res.pcm !== want.pcm) begin
                        $error("pcm mismatch: expected %0d, actual %0d", want.pcm, i_res.pcm);
                        fails++;
                    end
                    if (i_res.clipped !== want.clipped) begin
                        $error("clipped mismatch: expected %0d, actual %0d",
                               want.clipped, i_res.clipped);
                        fails++;
                    end
                end
            end
            if (i_smp.valid && i_smp.ready) begin
                absorb_sample(i_smp.sample);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                filt_on = i_cfg.filter_enable;
            end
        end
        o_fail_cnt <= fails;
        o_pending  <= expected_pcm.size();
    end

endmodule

>>> tb/sv/fir_decimate_to_pcm8_tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, sample and register stimulus, output stalls and verdict.
module fir_decimate_to_pcm8_tb;
    import fdp_pkg::*;

    localparam int RST_CYCLES  = 9;
    localparam int SETTLE      = 200;   // longer than one filtered word
    localparam int QUIET_LIMIT = 4000;

    typedef enum int {
        SM_NOISE,
        SM_SQUARE,
        SM_QUIET,
        SM_RAMP,
        SM_EXTREME,
        SM_HOLD
    } t_stim_mode;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CHOKE
    } t_rx_mode;

    localparam logic signed [SAMPLE_W-1:0] EXTREMES [10] = '{
        -32768, -32767, -256, -255, -1, 0, 1, 255, 256, 32767
    };
    localparam logic PHASE_EN  [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam int   PHASE_LEN [5] = '{200, 120, 200, 120, 160};

    logic clk;
    logic rst_n;
    int   fail_cnt;
    int   pending_cnt;
    int   burst_left;
    int   quiet_cycles;

    fdp_sample_if sample_ch ();
    fdp_result_if result_ch ();
    fdp_cfg_if    cfg_ch ();

    fir_decimate_to_pcm8 i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    fdp_pcm_checker i_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_smp      (sample_ch),
        .i_res      (result_ch),
        .i_cfg      (cfg_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending_cnt)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Send one word; bursts of random length with random gaps between them
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        int pick;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)       gap = 0;
            else if (pick < 8)  gap = $urandom_range(1, 8);
            else if (pick == 8) gap = $urandom_range(9, 60);
            else                gap = $urandom_range(61, 150);
            if (gap > 0) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 32);
        end
        burst_left--;
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= x;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
    endtask

    // Stop sending, wait for all words, then let a skipped sample finish
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_cnt != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_enable(input logic en);
        wait_drained();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.filter_enable <= en;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random phase: segments of noise, full-scale steps, small values, ramps, extremes and held levels
    task automatic run_random(input int n_items);
        t_stim_mode                 mode;
        int                         seg_left;
        int                         run_left;
        logic signed [SAMPLE_W-1:0] level;
        logic signed [SAMPLE_W-1:0] step;
        logic signed [SAMPLE_W-1:0] x;
        seg_left = 0;
        run_left = 0;
        level    = '0;
        step     = '0;
        repeat (n_items) begin
            if (seg_left == 0) begin
                mode     = t_stim_mode'($urandom_range(0, 5));
                seg_left = $urandom_range(16, 160);
                run_left = 0;
                level    = SAMPLE_W'($urandom);
                step     = SAMPLE_W'($urandom_range(1, 2000));
                if ($urandom_range(0, 1)) step = -step;
                if (mode == SM_HOLD && $urandom_range(0, 1)) level = 32767;
            end
            seg_left--;
            case (mode)
                SM_NOISE: begin
                    x = SAMPLE_W'($urandom);
                end
                SM_SQUARE: begin
                    // full-scale steps overshoot and clip at both rails
                    if (run_left == 0) begin
                        run_left = $urandom_range(1, 90);
                        level    = $urandom_range(0, 1) ? 32767 : -32768;
                    end
                    run_left--;
                    x = level;
                end
                SM_QUIET: begin
                    x = SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
                end
                SM_RAMP: begin
                    level = level + step;
                    x     = level;
                end
                SM_EXTREME: begin
                    x = EXTREMES[$urandom_range(0, 9)];
                end
                default: begin
                    x = level;
                end
            endcase
            push_sample(x);
        end
    endtask

    // Result ready: segments of open, coin-flip, sparse and choked patterns
    initial begin
        t_rx_mode rx_mode;
        int       seg_left;
        int       hold_left;
        logic     hold_val;
        result_ch.ready <= 1'b0;
        seg_left  = 0;
        hold_left = 0;
        hold_val  = 1'b0;
        forever begin
            @(posedge clk);
            if (seg_left == 0) begin
                rx_mode  = t_rx_mode'($urandom_range(0, 3));
                seg_left = $urandom_range(50, 400);
            end
            seg_left--;
            if (hold_left == 0) begin
                case (rx_mode)
                    RX_OPEN: begin
                        hold_val  = 1'b1;
                        hold_left = $urandom_range(1, 50);
                    end
                    RX_COIN: begin
                        hold_val  = 1'($urandom_range(0, 1));
                        hold_left = $urandom_range(1, 3);
                    end
                    RX_SPARSE: begin
                        hold_val  = ($urandom_range(0, 3) == 0);
                        hold_left = $urandom_range(1, 6);
                    end
                    default: begin
                        hold_val  = ~hold_val;
                        hold_left = hold_val ? $urandom_range(1, 3) : $urandom_range(20, 250);
                    end
                endcase
            end
            hold_left--;
            result_ch.ready <= hold_val;
        end
    end

    // Watchdog on cycles with no accepted word on any channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        rst_n                <= 1'b0;
        sample_ch.valid      <= 1'b0;
        sample_ch.sample     <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.filter_enable <= 1'b0;
        burst_left = 0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // filter on from reset, first sample kept; extremes on the zero history
        push_sample(32767);
        push_sample(-32768);
        push_sample(-32768);
        push_sample(32767);
        push_sample(0);
        push_sample(-1);

        // bypass: rails, truncation toward zero around the 1/256 step
        write_enable(1'b0);
        push_sample(32767);
        push_sample(-32768);
        push_sample(-32768);
        push_sample(32767);
        push_sample(-1);
        push_sample(12345);
        push_sample(-256);
        push_sample(-12345);
        push_sample(-255);
        push_sample(1);
        push_sample(255);
        push_sample(-1);
        push_sample(256);
        push_sample(0);
        push_sample(0);
        push_sample(32767);

        // random phases, toggling the filter between them
        for (int p = 0; p < 5; p++) begin
            write_enable(PHASE_EN[p]);
            run_random(PHASE_LEN[p]);
        end

        wait_drained();
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
